/* hw/rtl/sse_pkg.sv */
// sse_pkg: request types, control word layout, opcodes, jump conditions and
// step addresses shared by the shell sort sequencer, datapath and top level
// no dependencies
package sse_pkg;

    localparam int DATA_W = 32;
    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    // one input request
    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     final_item;
    } in_t;

    // one result request
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     run_end;
        logic                     dropped_flag;
    } out_t;

    // datapath operations, one per microstep
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_GAP_INIT   = 4'd2;
    localparam logic [OP_W-1:0] OP_I_FROM_GAP = 4'd3;
    localparam logic [OP_W-1:0] OP_READ_I     = 4'd4;
    localparam logic [OP_W-1:0] OP_LATCH_HELD = 4'd5;
    localparam logic [OP_W-1:0] OP_READ_PREV  = 4'd6;
    localparam logic [OP_W-1:0] OP_SHIFT      = 4'd7;
    localparam logic [OP_W-1:0] OP_PLACE      = 4'd8;
    localparam logic [OP_W-1:0] OP_HALVE      = 4'd9;
    localparam logic [OP_W-1:0] OP_READ_K     = 4'd10;
    localparam logic [OP_W-1:0] OP_EMIT       = 4'd11;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd12;

    // jump conditions: jump to target when true, else fall through
    localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] C_NOT_FIN    = 4'd2;
    localparam logic [COND_W-1:0] C_GAP_ZERO   = 4'd3;
    localparam logic [COND_W-1:0] C_I_GE_N     = 4'd4;
    localparam logic [COND_W-1:0] C_POS_LT_GAP = 4'd5;
    localparam logic [COND_W-1:0] C_NOT_GT     = 4'd6;
    localparam logic [COND_W-1:0] C_OUT_BUSY   = 4'd7;
    localparam logic [COND_W-1:0] C_K_LT_N     = 4'd8;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] S_LOAD     = 4'd0;
    localparam logic [STEP_W-1:0] S_GAP_INIT = 4'd1;
    localparam logic [STEP_W-1:0] S_PASS     = 4'd2;
    localparam logic [STEP_W-1:0] S_ELEM     = 4'd3;
    localparam logic [STEP_W-1:0] S_HOLD     = 4'd4;
    localparam logic [STEP_W-1:0] S_TEST     = 4'd5;
    localparam logic [STEP_W-1:0] S_CMP      = 4'd6;
    localparam logic [STEP_W-1:0] S_SHIFT    = 4'd7;
    localparam logic [STEP_W-1:0] S_PLACE    = 4'd8;
    localparam logic [STEP_W-1:0] S_NEXT_GAP = 4'd9;
    localparam logic [STEP_W-1:0] S_EMIT_RD  = 4'd10;
    localparam logic [STEP_W-1:0] S_EMIT_OUT = 4'd11;
    localparam logic [STEP_W-1:0] S_EMIT_CHK = 4'd12;
    localparam logic [STEP_W-1:0] S_DONE     = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } cw_t;

    // control from sequencer to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctrl_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic fin_acc;
        logic gap_zero;
        logic i_ge_n;
        logic pos_lt_gap;
        logic not_gt;
        logic out_busy;
        logic k_lt_n;
    } status_t;

endpackage

/* hw/rtl/sse_sequencer.sv */
// sse_sequencer: step counter, microprogram rom and conditional jump logic
// depends on sse_pkg
module sse_sequencer
(
    input  logic             clk,
    input  logic             rst_n,
    input  sse_pkg::status_t status,
    output sse_pkg::ctrl_t   ctrl
);

    logic [sse_pkg::STEP_W-1:0] step_reg;
    logic [sse_pkg::STEP_W-1:0] step_next;
    sse_pkg::cw_t               cw;
    logic                       take;

    function automatic sse_pkg::cw_t ucode_rom(input logic [sse_pkg::STEP_W-1:0] s);
        sse_pkg::cw_t w;
        begin
            w = '{op: sse_pkg::OP_NOP, cond: sse_pkg::C_ALWAYS, target: sse_pkg::S_LOAD};
            unique case (s)
                sse_pkg::S_LOAD:
                    w = '{sse_pkg::OP_LOAD, sse_pkg::C_NOT_FIN, sse_pkg::S_LOAD};
                sse_pkg::S_GAP_INIT:
                    w = '{sse_pkg::OP_GAP_INIT, sse_pkg::C_NEVER, sse_pkg::S_LOAD};
                sse_pkg::S_PASS:
                    w = '{sse_pkg::OP_I_FROM_GAP, sse_pkg::C_GAP_ZERO, sse_pkg::S_EMIT_RD};
                sse_pkg::S_ELEM:
                    w = '{sse_pkg::OP_READ_I, sse_pkg::C_I_GE_N, sse_pkg::S_NEXT_GAP};
                sse_pkg::S_HOLD:
                    w = '{sse_pkg::OP_LATCH_HELD, sse_pkg::C_NEVER, sse_pkg::S_LOAD};
                sse_pkg::S_TEST:
                    w = '{sse_pkg::OP_READ_PREV, sse_pkg::C_POS_LT_GAP, sse_pkg::S_PLACE};
                sse_pkg::S_CMP:
                    w = '{sse_pkg::OP_NOP, sse_pkg::C_NOT_GT, sse_pkg::S_PLACE};
                sse_pkg::S_SHIFT:
                    w = '{sse_pkg::OP_SHIFT, sse_pkg::C_ALWAYS, sse_pkg::S_TEST};
                sse_pkg::S_PLACE:
                    w = '{sse_pkg::OP_PLACE, sse_pkg::C_ALWAYS, sse_pkg::S_ELEM};
                sse_pkg::S_NEXT_GAP:
                    w = '{sse_pkg::OP_HALVE, sse_pkg::C_ALWAYS, sse_pkg::S_PASS};
                sse_pkg::S_EMIT_RD:
                    w = '{sse_pkg::OP_READ_K, sse_pkg::C_NEVER, sse_pkg::S_LOAD};
                sse_pkg::S_EMIT_OUT:
                    w = '{sse_pkg::OP_EMIT, sse_pkg::C_OUT_BUSY, sse_pkg::S_EMIT_OUT};
                sse_pkg::S_EMIT_CHK:
                    w = '{sse_pkg::OP_NOP, sse_pkg::C_K_LT_N, sse_pkg::S_EMIT_RD};
                sse_pkg::S_DONE:
                    w = '{sse_pkg::OP_CLEAR, sse_pkg::C_ALWAYS, sse_pkg::S_LOAD};
                default:
                    w = '{sse_pkg::OP_NOP, sse_pkg::C_ALWAYS, sse_pkg::S_LOAD};
            endcase
            return w;
        end
    endfunction

    assign cw = ucode_rom(step_reg);

    always_comb
    begin
        unique case (cw.cond)
            sse_pkg::C_NEVER:      take = 1'b0;
            sse_pkg::C_ALWAYS:     take = 1'b1;
            sse_pkg::C_NOT_FIN:    take = !status.fin_acc;
            sse_pkg::C_GAP_ZERO:   take = status.gap_zero;
            sse_pkg::C_I_GE_N:     take = status.i_ge_n;
            sse_pkg::C_POS_LT_GAP: take = status.pos_lt_gap;
            sse_pkg::C_NOT_GT:     take = status.not_gt;
            sse_pkg::C_OUT_BUSY:   take = status.out_busy;
            sse_pkg::C_K_LT_N:     take = status.k_lt_n;
            default:               take = 1'b1;
        endcase
    end

    assign step_next = take ? cw.target : step_reg + 1'b1;
    assign ctrl.op   = cw.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= sse_pkg::S_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* hw/rtl/sse_datapath.sv */
// sse_datapath: element memory, gap/index/position registers, comparator and
// output register of the shell sort engine
// depends on sse_pkg
module sse_datapath
#(
    parameter int CAPACITY = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sse_pkg::ctrl_t   ctrl,
    output sse_pkg::status_t status,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  sse_pkg::in_t     sample,
    output logic             result_valid,
    input  logic             result_ready,
    output sse_pkg::out_t    result
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic signed [sse_pkg::DATA_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    sse_pkg::out_t    out_reg;
    sse_pkg::out_t    out_next;

    logic [CNT_W-1:0] gap_reg;
    logic [CNT_W-1:0] gap_next;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] pos_next;
    logic signed [sse_pkg::DATA_W-1:0] held_reg;
    logic signed [sse_pkg::DATA_W-1:0] held_next;
    logic signed [sse_pkg::DATA_W-1:0] rdata_reg;

    logic                              accept;
    logic                              rd_en;
    logic [CNT_W-1:0]                  rd_cnt;
    logic                              wr_en;
    logic [CNT_W-1:0]                  wr_cnt;
    logic signed [sse_pkg::DATA_W-1:0] wr_data;
    logic [CNT_W-1:0]                  pos_minus_gap;
    logic                              out_busy;

    assign sample_ready  = (ctrl.op == sse_pkg::OP_LOAD);
    assign accept        = sample_valid && sample_ready;
    assign pos_minus_gap = pos_reg - gap_reg;
    assign out_busy      = out_valid_reg && !result_ready;

    assign status.fin_acc    = accept && sample.final_item;
    assign status.gap_zero   = (gap_reg == '0);
    assign status.i_ge_n     = (i_reg >= fill_reg);
    assign status.pos_lt_gap = (pos_reg < gap_reg);
    assign status.not_gt     = !(rdata_reg > held_reg);
    assign status.out_busy   = out_busy;
    assign status.k_lt_n     = (k_reg < fill_reg);

    always_comb
    begin
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        gap_next       = gap_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        rd_en          = 1'b0;
        rd_cnt         = i_reg;
        wr_en          = 1'b0;
        wr_cnt         = pos_reg;
        wr_data        = held_reg;
        unique case (ctrl.op)
            sse_pkg::OP_LOAD:
            begin
                if (accept)
                begin
                    if (fill_reg < CAP_C)
                    begin
                        wr_en     = 1'b1;
                        wr_cnt    = fill_reg;
                        wr_data   = sample.sample_value;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            sse_pkg::OP_GAP_INIT:   gap_next = fill_reg >> 1;
            sse_pkg::OP_I_FROM_GAP: i_next   = gap_reg;
            sse_pkg::OP_READ_I:
            begin
                rd_en    = 1'b1;
                rd_cnt   = i_reg;
                pos_next = i_reg;
            end
            sse_pkg::OP_LATCH_HELD: held_next = rdata_reg;
            sse_pkg::OP_READ_PREV:
            begin
                rd_en  = 1'b1;
                rd_cnt = pos_minus_gap;
            end
            sse_pkg::OP_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_cnt   = pos_reg;
                wr_data  = rdata_reg;
                pos_next = pos_minus_gap;
            end
            sse_pkg::OP_PLACE:
            begin
                wr_en   = 1'b1;
                wr_cnt  = pos_reg;
                wr_data = held_reg;
                i_next  = i_reg + 1'b1;
            end
            sse_pkg::OP_HALVE: gap_next = gap_reg >> 1;
            sse_pkg::OP_READ_K:
            begin
                rd_en  = 1'b1;
                rd_cnt = k_reg;
            end
            sse_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_next.sorted_value = rdata_reg;
                    out_next.run_end      = (k_reg + 1'b1 == fill_reg);
                    out_next.dropped_flag = ovf_reg;
                    out_valid_next        = 1'b1;
                    k_next                = k_reg + 1'b1;
                end
            end
            sse_pkg::OP_CLEAR:
            begin
                fill_next = '0;
                ovf_next  = 1'b0;
                k_next    = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    // element store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_cnt[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_cnt[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg  <= gap_next;
        i_reg    <= i_next;
        pos_reg  <= pos_next;
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hw/rtl/shell_sort_engine.sv */
// shell_sort_engine: top level of the microcoded shell sort engine
// depends on sse_pkg, sse_sequencer and sse_datapath
//
// usage
//   sample channel (sample_valid / sample_ready / sample): one signed q16.16
//   value per request, written into the element store in arrival order; a
//   request with final_item set closes the set and starts the sort
//   result channel (result_valid / result_ready / result): the n stored values
//   in ascending order, run_end on the last one, dropped_flag on every result
//   of a run in which requests beyond CAPACITY were discarded
// timing
//   a request is taken whenever sample_valid is high while sample_ready is;
//   sample_ready is high only while the sequencer sits in its load step
//   the sort is a gapped insertion pass per gap n/2 .. 1, stepped around the
//   registered read of the element memory: each element visit reads the
//   element, latches it as held, compares it with the neighbour one gap back
//   (if any) and places it; a shift moves that neighbour one gap up
//   results then leave one at a time, each read and emitted before the next;
//   after the last one the block clears and returns to loading
// reset
//   asynchronous, clears the step counter, fill count, dropped mark, emit
//   index and the output valid; the element store keeps whatever it held
// stalls
//   the output register holds its request while result_ready is low and the
//   sequencer waits in its emit step, nothing is lost
module shell_sort_engine
#(
    parameter int CAPACITY = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_ready,
    input  sse_pkg::in_t  sample,
    output logic          result_valid,
    input  logic          result_ready,
    output sse_pkg::out_t result
);

    sse_pkg::ctrl_t   ctrl;
    sse_pkg::status_t status;

    // step counter and microprogram rom
    sse_sequencer u_sequencer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // element memory, loop registers, comparator and output register
    sse_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* hw/rtl/sse_checker.sv */
// sse_checker: port level checks for the shell sort engine, bound to the top
// depends on sse_pkg and shell_sort_engine
module sse_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    input  logic          sample_ready,
    input  sse_pkg::in_t  sample,
    input  logic          result_valid,
    input  logic          result_ready,
    input  sse_pkg::out_t result
);

    // a stalled result request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result request changed while stalled");

    // a closing request stops loading at once
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && sample.final_item |=> !sample_ready)
    else $error("still loading after final item");

    // mid-run result taken means the run is still going
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.run_end |=> !sample_ready)
    else $error("loading resumed in the middle of a run");

    // no unfinished run pending while loading
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !(result_valid && !result.run_end))
    else $error("loading with a mid-run result pending");

endmodule

bind shell_sort_engine sse_checker u_checker (.*);
